// ===== sv/tcw_pkg.sv =====
package tcw_pkg;

  localparam logic [1:0] KIND_PRINT = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [15:0] BLANK_CELL  = 16'h0000;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [10:0] cell_index;
    logic        in_range;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ
  } state_e;

endpackage

// ===== sv/tcw_in_if.sv =====
interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  char_code;
  logic [7:0]  attribute;
  logic [10:0] cell_index;

  modport source (output valid, output kind, output char_code, output attribute,
                  output cell_index, input ready);
  modport sink (input valid, input kind, input char_code, input attribute,
                input cell_index, output ready);
endinterface

// ===== sv/tcw_out_if.sv =====
interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_cell;
  logic [7:0]  read_char;
  logic [7:0]  read_attr;
  logic        scrolled;

  modport source (output valid, output cursor_cell, output read_char, output read_attr,
                  output scrolled, input ready);
  modport sink (input valid, input cursor_cell, input read_char, input read_attr,
                input scrolled, output ready);
endinterface

// ===== sv/tcw_front.sv =====
module tcw_front import tcw_pkg::*; #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  tcw_in_if.sink in_if,
  input  logic   init_busy_i,
  input  logic   cmd_ready_i,
  output logic   cmd_valid_o,
  output cmd_t   cmd_o
);

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;

  // no transfer while the reset clearing pass runs
  assign in_if.ready = cmd_ready_i && !init_busy_i;
  assign cmd_valid_o = in_if.valid && !init_busy_i;

  always_comb begin
    cmd_o.char_code  = in_if.char_code;
    cmd_o.attribute  = in_if.attribute;
    cmd_o.cell_index = in_if.cell_index;
    cmd_o.in_range   = 32'(in_if.cell_index) < 32'(CELLS);
    case (in_if.kind)
      KIND_PRINT: begin
        cmd_o.op = (in_if.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_CHAR;
      end
      KIND_CLEAR: begin
        cmd_o.op = OP_CLEAR;
      end
      KIND_READ: begin
        cmd_o.op = OP_READ;
      end
      default: begin
        cmd_o.op = OP_NOP;
      end
    endcase
  end

endmodule

// ===== sv/tcw_cmd_fifo.sv =====
module tcw_cmd_fifo import tcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int DEPTH = 2;

  cmd_t       ent_q [DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'(DEPTH);
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_cmd_o    = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== sv/tcw_back.sv =====
module tcw_back import tcw_pkg::*; #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cmd_valid_i,
  output logic   cmd_ready_o,
  input  cmd_t   cmd_i,
  output logic   init_busy_o,
  tcw_out_if.source out_if
);

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(SCREEN_ROWS + 1);
  localparam int CLW   = $clog2(SCREEN_COLUMNS);

  state_e        state_q, state_d;
  logic [CW-1:0] sw_q, sw_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [RW-1:0] row_q, row_d;
  logic [CLW-1:0] col_q, col_d;
  logic          flag_q, flag_d;

  logic [15:0]   mem_q [CELLS];
  logic [15:0]   rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;

  logic          out_valid_q;
  logic [10:0]   cursor_cell_q;
  logic [7:0]    read_char_q, read_attr_q;
  logic          scrolled_q;
  logic          out_free, out_load;
  logic [7:0]    ld_char, ld_attr;
  logic          ld_scrolled;

  logic          take, past_bottom, sw_last_fill, sw_last_move;
  logic [CW-1:0] sw_rd, sw_wr;
  logic [AW+10:0] idx_ext;
  logic [CW+10:0] cur_ext;

  assign out_free     = !out_valid_q || out_if.ready;
  assign take         = cmd_valid_i && out_free;
  assign past_bottom  = row_q == RW'(SCREEN_ROWS);
  assign sw_last_fill = sw_q == CW'(CELLS - 1);
  assign sw_last_move = sw_q == CW'(CELLS);
  assign sw_rd        = sw_q + CW'(SCREEN_COLUMNS);
  assign sw_wr        = sw_q - CW'(1);
  assign idx_ext      = {{AW{1'b0}}, cmd_i.cell_index};
  assign cur_ext      = {11'd0, cursor_d};
  assign init_busy_o  = state_q == ST_INIT;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sw_last_fill) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) begin
          case (cmd_i.op)
            OP_CHAR, OP_NEWLINE: begin
              if (past_bottom) state_d = ST_SCROLL;
            end
            OP_CLEAR: state_d = ST_CLEAR;
            OP_READ: begin
              if (cmd_i.in_range) state_d = ST_READ;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCROLL: begin
        if (sw_last_move) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (sw_last_fill && out_free) state_d = ST_IDLE;
      end
      ST_READ: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sw_d        = sw_q;
    cursor_d    = cursor_q;
    row_d       = row_q;
    col_d       = col_q;
    flag_d      = flag_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = BLANK_CELL;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    cmd_ready_o = 1'b0;
    out_load    = 1'b0;
    ld_char     = 8'd0;
    ld_attr     = 8'd0;
    ld_scrolled = 1'b0;
    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sw_q[AW-1:0];
        sw_d      = sw_last_fill ? '0 : sw_q + CW'(1);
      end
      ST_IDLE: begin
        if (take) begin
          case (cmd_i.op)
            OP_CHAR: begin
              if (!past_bottom) begin
                mem_we      = 1'b1;
                mem_waddr   = cursor_q[AW-1:0];
                mem_wdata   = {cmd_i.attribute, cmd_i.char_code};
                cursor_d    = cursor_q + CW'(1);
                if (col_q == CLW'(SCREEN_COLUMNS - 1)) begin
                  col_d = '0;
                  row_d = row_q + RW'(1);
                end else begin
                  col_d = col_q + CLW'(1);
                end
                cmd_ready_o = 1'b1;
                out_load    = 1'b1;
                ld_scrolled = flag_q;
                flag_d      = 1'b0;
              end
            end
            OP_NEWLINE: begin
              if (!past_bottom) begin
                cursor_d    = cursor_q + CW'(SCREEN_COLUMNS) - CW'(col_q);
                col_d       = '0;
                row_d       = row_q + RW'(1);
                cmd_ready_o = 1'b1;
                out_load    = 1'b1;
                ld_scrolled = flag_q;
                flag_d      = 1'b0;
              end
            end
            OP_CLEAR: begin
              sw_d = '0;
            end
            OP_READ: begin
              if (cmd_i.in_range) begin
                mem_re    = 1'b1;
                mem_raddr = idx_ext[AW-1:0];
              end else begin
                cmd_ready_o = 1'b1;
                out_load    = 1'b1;
              end
            end
            default: begin
              cmd_ready_o = 1'b1;
              out_load    = 1'b1;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // read one row ahead, write back the cell fetched last cycle
        if (sw_q < CW'(CELLS - SCREEN_COLUMNS)) begin
          mem_re    = 1'b1;
          mem_raddr = sw_rd[AW-1:0];
        end
        if (sw_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = sw_wr[AW-1:0];
          mem_wdata = (sw_q <= CW'(CELLS - SCREEN_COLUMNS)) ? rdata_q : BLANK_CELL;
        end
        if (sw_last_move) begin
          sw_d     = '0;
          cursor_d = CW'(CELLS - SCREEN_COLUMNS);
          row_d    = RW'(SCREEN_ROWS - 1);
          col_d    = '0;
          flag_d   = 1'b1;
        end else begin
          sw_d = sw_q + CW'(1);
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sw_q[AW-1:0];
        if (sw_last_fill) begin
          if (out_free) begin
            sw_d        = '0;
            cursor_d    = '0;
            row_d       = '0;
            col_d       = '0;
            cmd_ready_o = 1'b1;
            out_load    = 1'b1;
          end
        end else begin
          sw_d = sw_q + CW'(1);
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd_ready_o = 1'b1;
          out_load    = 1'b1;
          ld_char     = rdata_q[7:0];
          ld_attr     = rdata_q[15:8];
        end
      end
      default: begin
        sw_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sw_q        <= '0;
      cursor_q    <= '0;
      row_q       <= '0;
      col_q       <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sw_q        <= sw_d;
      cursor_q    <= cursor_d;
      row_q       <= row_d;
      col_q       <= col_d;
      flag_q      <= flag_d;
      out_valid_q <= out_load || (out_valid_q && !out_if.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cursor_cell_q <= cur_ext[10:0];
      read_char_q   <= ld_char;
      read_attr_q   <= ld_attr;
      scrolled_q    <= ld_scrolled;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.cursor_cell = cursor_cell_q;
  assign out_if.read_char   = read_char_q;
  assign out_if.read_attr   = read_attr_q;
  assign out_if.scrolled    = scrolled_q;

endmodule

// ===== sv/text_console_writer.sv =====
// Text console writer. Items enter on in_if and are classified into a two-entry
// command queue, so a new item is taken while the queue has room, also while the
// engine is busy or a result waits on out_if. The engine owns a simple dual-port
// screen buffer of SCREEN_COLUMNS x SCREEN_ROWS 16-bit cells (one write and one
// registered read per cycle), and that buffer sets the timing: a printed
// character or newline is handled directly in the idle state, a read goes through
// the registered buffer read before its result is loaded, a clear writes every
// cell in turn, and a print at the cursor past the bottom row first runs a scroll
// that moves the buffer one cell per cycle. After reset the buffer is zeroed by a
// pass over every cell during which in_if.ready stays low.
module text_console_writer import tcw_pkg::*; #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_in_if.sink    in_if,
  tcw_out_if.source out_if
);

  logic init_busy;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  tcw_front #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_front (
    .in_if      (in_if),
    .init_busy_i(init_busy),
    .cmd_ready_i(push_ready),
    .cmd_valid_o(push_valid),
    .cmd_o      (push_cmd)
  );

  tcw_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (cmd_valid),
    .pop_ready_i (cmd_ready),
    .pop_cmd_o   (cmd)
  );

  tcw_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .init_busy_o(init_busy),
    .out_if     (out_if)
  );

  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_busy |=> !init_busy)
    else $error("reset clearing pass restarted");

  a_queue_empty_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !cmd_valid)
    else $error("command queued during reset clearing pass");

  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |=> out_if.valid)
    else $error("finished command left no result");

endmodule

// ===== test/text_console_writer_test.sv =====
module text_console_writer_test import tcw_pkg::*; ();

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam int HOLD_CYCLES = 120;
  localparam int RANDOM_ITEMS = 800;
  localparam int TAIL_ITEMS = 150;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [10:0] cell_index;
  } console_cmd_t;

  typedef struct packed {
    logic [10:0] cursor_cell;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        scrolled;
  } console_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tcw_in_if in_if ();
  tcw_out_if out_if ();

  text_console_writer #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS   (ROWS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  logic [15:0] screen_model [CELLS];
  int cursor_model;
  console_reply_t pending_replies [$];
  int fault_count = 0;
  bit idle_enabled = 1'b1;
  bit hold_request = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = KIND_PRINT;
    in_if.char_code = 8'd0;
    in_if.attribute = 8'd0;
    in_if.cell_index = 11'd0;
  end

  function automatic console_reply_t apply_to_screen(console_cmd_t cmd);
    console_reply_t reply;
    int row;
    int col;
    int pos;
    reply = '0;
    case (cmd.kind)
      KIND_PRINT: begin
        row = cursor_model / COLS;
        col = cursor_model % COLS;
        if (row >= ROWS) begin
          for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
          reply.scrolled = 1'b1;
          row = ROWS - 1;
          col = 0;
        end
        if (cmd.char_code == NEWLINE_CODE) begin
          cursor_model = (row + 1) * COLS;
        end else begin
          pos = row * COLS + col;
          screen_model[pos] = {cmd.attribute, cmd.char_code};
          cursor_model = pos + 1;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        cursor_model = 0;
      end
      KIND_READ: begin
        if (cmd.cell_index < CELLS) begin
          reply.read_char = screen_model[cmd.cell_index][7:0];
          reply.read_attr = screen_model[cmd.cell_index][15:8];
        end
      end
      default: ;
    endcase
    reply.cursor_cell = 11'(cursor_model);
    return reply;
  endfunction

  function automatic console_cmd_t make_cmd(logic [1:0] kind, logic [7:0] ch, logic [7:0] attr,
                                            logic [10:0] idx);
    console_cmd_t cmd;
    cmd.kind = kind;
    cmd.char_code = ch;
    cmd.attribute = attr;
    cmd.cell_index = idx;
    return cmd;
  endfunction

  // reads aim at cells near the cursor in 40% of picks so written text gets read back
  function automatic logic [10:0] pick_read_cell();
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      idx = cursor_model - int'($urandom_range(1, 160));
      if (idx < 0) idx = $urandom_range(0, CELLS - 1);
    end else if (pick < 75) begin
      idx = $urandom_range(0, CELLS - 1);
    end else if (pick < 85) begin
      idx = $urandom_range(CELLS, 2047);
    end else begin
      case ($urandom_range(0, 3))
        0: idx = 0;
        1: idx = COLS - 1;
        2: idx = CELLS - COLS;
        default: idx = CELLS - 1;
      endcase
    end
    return 11'(idx);
  endfunction

  function automatic console_cmd_t random_cmd(int newline_pct);
    console_cmd_t cmd;
    int pick;
    pick = $urandom_range(0, 99);
    cmd = make_cmd(KIND_PRINT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   11'($urandom_range(0, 2047)));
    if (pick < 1) begin
      cmd.kind = KIND_CLEAR;
    end else if (pick < 3) begin
      cmd.kind = KIND_UNUSED;
    end else if (pick < 33) begin
      cmd.kind = KIND_READ;
      cmd.cell_index = pick_read_cell();
    end else if ($urandom_range(0, 99) < newline_pct) begin
      cmd.char_code = NEWLINE_CODE;
    end
    return cmd;
  endfunction

  task automatic send_item(input console_cmd_t cmd);
    int gap;
    @(negedge clk);
    if (idle_enabled && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.kind = cmd.kind;
    in_if.char_code = cmd.char_code;
    in_if.attribute = cmd.attribute;
    in_if.cell_index = cmd.cell_index;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_replies.push_back(apply_to_screen(cmd));
  endtask

  // reply side: random stalls, plus one long hold-off on request
  initial begin
    int burst;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        out_if.ready = 1'b0;
        burst = $urandom_range(1, 3);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin
    console_reply_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected transfer: cursor_cell %0d", out_if.cursor_cell);
        fault_count++;
      end else begin
        want = pending_replies.pop_front();
        compare_field("cursor_cell", want.cursor_cell, out_if.cursor_cell);
        compare_field("read_char", want.read_char, out_if.read_char);
        compare_field("read_attr", want.read_attr, out_if.read_attr);
        compare_field("scrolled", want.scrolled, out_if.scrolled);
      end
    end
  end

  task automatic check_blank_screen();
    send_item(make_cmd(KIND_READ, 8'd0, 8'd0, 11'd0));
    send_item(make_cmd(KIND_READ, 8'hff, 8'hff, 11'(CELLS - 1)));
    send_item(make_cmd(KIND_READ, 8'd0, 8'd0, 11'h7ff));
    send_item(make_cmd(KIND_UNUSED, 8'hff, 8'hff, 11'h7ff));
  endtask

  task automatic check_print_and_newline();
    send_item(make_cmd(KIND_PRINT, 8'h00, 8'h00, 11'd0));
    send_item(make_cmd(KIND_PRINT, 8'hff, 8'hff, 11'h7ff));
    send_item(make_cmd(KIND_PRINT, 8'haa, 8'h55, 11'd0));
    send_item(make_cmd(KIND_PRINT, NEWLINE_CODE, 8'hff, 11'd0));
    send_item(make_cmd(KIND_PRINT, 8'h55, 8'haa, 11'h555));
    send_item(make_cmd(KIND_READ, 8'd0, 8'd0, 11'd0));
    send_item(make_cmd(KIND_READ, 8'd0, 8'd0, 11'd1));
    send_item(make_cmd(KIND_READ, 8'd0, 8'd0, 11'd2));
    send_item(make_cmd(KIND_READ, 8'd0, 8'd0, 11'(COLS)));
    send_item(make_cmd(KIND_READ, 8'd0, 8'd0, 11'(COLS - 1)));
  endtask

  // walk down to the last row, then print and newline past the bottom
  task automatic check_scroll();
    send_item(make_cmd(KIND_CLEAR, 8'd0, 8'd0, 11'd0));
    send_item(make_cmd(KIND_PRINT, 8'h41, 8'h1f, 11'd0));
    repeat (ROWS - 1) send_item(make_cmd(KIND_PRINT, NEWLINE_CODE, 8'h07, 11'd0));
    send_item(make_cmd(KIND_PRINT, 8'h42, 8'h2e, 11'd0));
    send_item(make_cmd(KIND_PRINT, NEWLINE_CODE, 8'h00, 11'd0));
    send_item(make_cmd(KIND_PRINT, 8'h43, 8'h4c, 11'd0));
    send_item(make_cmd(KIND_PRINT, NEWLINE_CODE, 8'h00, 11'd0));
    send_item(make_cmd(KIND_PRINT, NEWLINE_CODE, 8'h00, 11'd0));
    send_item(make_cmd(KIND_READ, 8'd0, 8'd0, 11'(CELLS - 3 * COLS)));
    send_item(make_cmd(KIND_READ, 8'd0, 8'd0, 11'(CELLS - 2 * COLS)));
    send_item(make_cmd(KIND_READ, 8'd0, 8'd0, 11'(CELLS - COLS)));
  endtask

  task automatic check_clear();
    send_item(make_cmd(KIND_CLEAR, 8'hff, 8'hff, 11'h7ff));
    send_item(make_cmd(KIND_READ, 8'd0, 8'd0, 11'(CELLS - 2 * COLS)));
    send_item(make_cmd(KIND_UNUSED, 8'd0, 8'd0, 11'd0));
  endtask

  task automatic run_random_text();
    int sent;
    int burst_len;
    int newline_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(20, 60);
      newline_pct = $urandom_range(2, 45);
      idle_enabled = ($urandom_range(0, 3) != 0);
      repeat (burst_len) begin
        send_item(random_cmd(newline_pct));
        sent++;
      end
    end
  endtask

  task automatic check_reply_stall();
    idle_enabled = 1'b0;
    hold_request = 1'b1;
    repeat (12) send_item(random_cmd(20));
  endtask

  task automatic run_steady_tail();
    idle_enabled = 1'b0;
    repeat (TAIL_ITEMS) send_item(random_cmd(25));
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
    cursor_model = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    check_blank_screen();
    check_print_and_newline();
    check_scroll();
    check_clear();
    run_random_text();
    check_reply_stall();
    run_steady_tail();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #150000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tcw_pkg.sv
sv/tcw_in_if.sv
sv/tcw_out_if.sv
sv/tcw_front.sv
sv/tcw_cmd_fifo.sv
sv/tcw_back.sv
sv/text_console_writer.sv
test/text_console_writer_test.sv
